// ===== rtl/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared widths, field types, request and status codes, and the memory
// command group of the positional insert/delete list unit.
// ----------------------------------------------------------------------------
package pidl_pkg;

	// fixed field widths of the request and response channels
	localparam int REQ_W = 2;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int TOT_W = 7;
	localparam int ST_W  = 2;

	typedef logic [REQ_W-1:0] code_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [VAL_W-1:0] value_t;
	typedef logic [TOT_W-1:0] total_t;
	typedef logic [ST_W-1:0]  status_t;

	// request codes
	localparam code_t REQ_READ   = 2'd0;
	localparam code_t REQ_WRITE  = 2'd1;
	localparam code_t REQ_INSERT = 2'd2;
	localparam code_t REQ_DELETE = 2'd3;

	// status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// memory port enables from the sequencer
	typedef struct packed {
		logic wr;
		logic rd;
	} ram_ctl_t;

endpackage

// ===== rtl/pidl_req_if.sv =====
// ----------------------------------------------------------------------------
// pidl_req_if
// Request channel: valid/ready handshake with request code, position and
// new entry data.
// ----------------------------------------------------------------------------
interface pidl_req_if;

	logic             valid;
	logic             ready;
	pidl_pkg::code_t  req_type;
	pidl_pkg::pos_t   position;
	pidl_pkg::value_t new_value;

	modport source (output valid, output req_type, output position, output new_value,
		input ready);
	modport sink (input valid, input req_type, input position, input new_value,
		output ready);

endinterface

// ===== rtl/pidl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pidl_rsp_if
// Response channel: valid/ready handshake with read entry, entry total and
// status.
// ----------------------------------------------------------------------------
interface pidl_rsp_if;

	logic              valid;
	logic              ready;
	pidl_pkg::value_t  read_value;
	pidl_pkg::total_t  entry_total;
	pidl_pkg::status_t status;

	modport source (output valid, output read_value, output entry_total, output status,
		input ready);
	modport sink (input valid, input read_value, input entry_total, input status,
		output ready);

endinterface

// ===== rtl/positional_insert_delete_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit
// Ordered list of entries addressed by position: read, overwrite, insert
// before and delete at a position, with one response per request.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   req_type, position, new_value
//  rsp      out  valid/ready   read_value, entry_total, status
//
// One request is worked at a time; a finished response waits in the output
// register while the next request is taken.
// Read, overwrite and rejected requests pass through the RESP state into the
// output register. Insert and delete move the entries behind the position,
// one entry moved per cycle through the single write port of the store, and
// then pass through RESP; an append or a delete of the last entry moves none.
// A busy output register adds its stall before the response is loaded.
// Reset clears the count and control; the entry store is not cleared.
// A stalled response holds its payload; no request is lost while it waits.
//
module positional_insert_delete_list_unit #(
	parameter int CAPACITY    = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	pidl_req_if.sink    req,
	pidl_rsp_if.source  rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam pidl_pkg::total_t CAP_TOT = pidl_pkg::total_t'(CAPACITY);

	pidl_pkg::ram_ctl_t     ram_ctl;
	logic [AW-1:0]          ram_waddr;
	logic [AW-1:0]          ram_raddr;
	logic [ENTRY_WIDTH-1:0] ram_wdata;
	logic [ENTRY_WIDTH-1:0] ram_rdata;

	// sequencer
	pidl_engine #(
		.CAPACITY    (CAPACITY),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram_ctl   (ram_ctl),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// entry store
	pidl_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ENTRY_WIDTH)
	) u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one request in flight: no transaction right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in progress");

	// a full-list rejection reports the capacity as total
	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == pidl_pkg::ST_FULL |-> rsp.entry_total == CAP_TOT)
		else $error("list full status with total below capacity");

	// failed requests never return entry data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != pidl_pkg::ST_OK |-> rsp.read_value == '0)
		else $error("nonzero read value on failed request");

endmodule

// ===== rtl/pidl_ram.sv =====
// ----------------------------------------------------------------------------
// pidl_ram
// Entry store: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module pidl_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  pidl_pkg::ram_ctl_t   ctl,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/pidl_engine.sv =====
// ----------------------------------------------------------------------------
// pidl_engine
// Request sequencer: range checks, entry count, shift loop over the entry
// store for insert and delete, and the response output register.
// ----------------------------------------------------------------------------
module pidl_engine #(
	parameter int CAPACITY    = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	pidl_req_if.sink                     req,
	pidl_rsp_if.source                   rsp,
	output pidl_pkg::ram_ctl_t           ram_ctl,
	output logic [$clog2(CAPACITY)-1:0]  ram_waddr,
	output logic [ENTRY_WIDTH-1:0]       ram_wdata,
	output logic [$clog2(CAPACITY)-1:0]  ram_raddr,
	input  logic [ENTRY_WIDTH-1:0]       ram_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;

	typedef enum logic [1:0] {
		IDLE,
		SHIFT,
		RESP
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             ptr_q;
	logic [AW-1:0]             end_q;
	logic [AW-1:0]             dst_q;
	logic                      up_q;
	logic                      fin_q;
	logic                      pend_q;
	logic                      rdsel_q;
	logic [ENTRY_WIDTH-1:0]    val_q;
	pidl_pkg::status_t         st_q;
	logic                      out_valid_q;
	pidl_pkg::value_t          out_rd_q;
	pidl_pkg::total_t          out_tot_q;
	pidl_pkg::status_t         out_st_q;

	logic                                 acc;
	logic [XW-1:0]                        pos_x;
	logic [XW-1:0]                        cnt_x;
	logic [AW-1:0]                        pos_a;
	logic [CW-1:0]                        cnt_m1;
	logic [AW-1:0]                        del_p;
	logic                                 rw_ok;
	logic                                 ins_rng;
	logic                                 is_full;
	logic                                 del_rng;
	logic [AW-1:0]                        shift_src;
	logic [ENTRY_WIDTH+pidl_pkg::VAL_W-1:0] wr_ext;
	logic [ENTRY_WIDTH+pidl_pkg::VAL_W-1:0] rd_ext;

	// handshake and response payload
	assign acc             = req.valid && req.ready;
	assign req.ready       = (state_q == IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_rd_q;
	assign rsp.entry_total = out_tot_q;
	assign rsp.status      = out_st_q;

	// range checks against the current count
	assign pos_x   = XW'(req.position);
	assign cnt_x   = XW'(count_q);
	assign pos_a   = pos_x[AW-1:0];
	assign cnt_m1  = count_q - CW'(1);
	assign rw_ok   = (pos_x < cnt_x);
	assign ins_rng = (pos_x > cnt_x);
	assign is_full = (count_q == CW'(CAPACITY));
	assign del_rng = (count_q == '0) || (pos_x > cnt_x);
	// delete at the end position removes the last entry
	assign del_p   = (pos_x == cnt_x) ? cnt_m1[AW-1:0] : pos_a;

	// entry data sizing on the way in and out
	assign wr_ext = {{ENTRY_WIDTH{1'b0}}, req.new_value};
	assign rd_ext = {{pidl_pkg::VAL_W{1'b0}}, ram_rdata};

	// next source entry of the shift loop
	assign shift_src = up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));

	// memory port control
	always_comb begin
		ram_ctl   = '0;
		ram_waddr = dst_q;
		ram_wdata = ram_rdata;
		ram_raddr = shift_src;
		unique case (state_q)
			IDLE: begin
				if (acc && rw_ok) begin
					if (req.req_type == pidl_pkg::REQ_READ) begin
						ram_ctl.rd = 1'b1;
						ram_raddr  = pos_a;
					end else if (req.req_type == pidl_pkg::REQ_WRITE) begin
						ram_ctl.wr = 1'b1;
						ram_waddr  = pos_a;
						ram_wdata  = wr_ext[ENTRY_WIDTH-1:0];
					end
				end
			end
			SHIFT: begin
				// move the entry read last cycle; for an insert, then drop in the new one
				if (pend_q) begin
					ram_ctl.wr = 1'b1;
				end else if (ptr_q == end_q && fin_q) begin
					ram_ctl.wr = 1'b1;
					ram_waddr  = end_q;
					ram_wdata  = val_q;
				end
				if (ptr_q != end_q) begin
					ram_ctl.rd = 1'b1;
				end
			end
			RESP: begin
			end
			default: begin
			end
		endcase
	end

	// state, count and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			end_q       <= '0;
			dst_q       <= '0;
			up_q        <= 1'b0;
			fin_q       <= 1'b0;
			pend_q      <= 1'b0;
			rdsel_q     <= 1'b0;
			val_q       <= '0;
			st_q        <= pidl_pkg::ST_OK;
			out_valid_q <= 1'b0;
			out_rd_q    <= '0;
			out_tot_q   <= '0;
			out_st_q    <= pidl_pkg::ST_OK;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (acc) begin
						rdsel_q <= 1'b0;
						pend_q  <= 1'b0;
						st_q    <= pidl_pkg::ST_OK;
						state_q <= RESP;
						unique case (req.req_type)
							pidl_pkg::REQ_READ: begin
								rdsel_q <= rw_ok;
								if (!rw_ok) begin
									st_q <= pidl_pkg::ST_RANGE;
								end
							end
							pidl_pkg::REQ_WRITE: begin
								if (!rw_ok) begin
									st_q <= pidl_pkg::ST_RANGE;
								end
							end
							pidl_pkg::REQ_INSERT: begin
								if (ins_rng) begin
									st_q <= pidl_pkg::ST_RANGE;
								end else if (is_full) begin
									st_q <= pidl_pkg::ST_FULL;
								end else begin
									ptr_q   <= count_q[AW-1:0];
									end_q   <= pos_a;
									up_q    <= 1'b1;
									fin_q   <= 1'b1;
									val_q   <= wr_ext[ENTRY_WIDTH-1:0];
									count_q <= count_q + CW'(1);
									state_q <= SHIFT;
								end
							end
							pidl_pkg::REQ_DELETE: begin
								if (del_rng) begin
									st_q <= pidl_pkg::ST_RANGE;
								end else begin
									ptr_q   <= del_p;
									end_q   <= cnt_m1[AW-1:0];
									up_q    <= 1'b0;
									fin_q   <= 1'b0;
									count_q <= cnt_m1;
									state_q <= SHIFT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				SHIFT: begin
					if (ptr_q != end_q) begin
						ptr_q  <= shift_src;
						dst_q  <= ptr_q;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= RESP;
						end
					end
				end
				RESP: begin
					// load the output register once it is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_rd_q    <= rdsel_q ? rd_ext[pidl_pkg::VAL_W-1:0] : '0;
						out_tot_q   <= cnt_x[pidl_pkg::TOT_W-1:0];
						out_st_q    <= st_q;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
